// ----- rtl/core/tft_window_pixel_writer_macros.svh -----
// ----------------------------------------------------------------------------
// TFT window pixel writer assertion macros
// Shared concurrent assertion forms for the pixel writer RTL. Each macro
// expands to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TFT_WINDOW_PIXEL_WRITER_MACROS_SVH
`define TFT_WINDOW_PIXEL_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define TWP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel writer check failed");

// Next-cycle implication, checked outside reset.
`define TWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel writer check failed");

`else

`define TWP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TWP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/twp_pkg.sv -----
// ----------------------------------------------------------------------------
// TFT window pixel writer package
// Types, codes and defaults shared by the pixel writer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package twp_pkg;

   // Default panel geometry.
   localparam int DEFAULT_PANEL_WIDTH  = 480;
   localparam int DEFAULT_PANEL_HEIGHT = 272;

   // Reset values of the command code registers.
   localparam logic [7:0] RESET_COLUMN_CMD = 8'd42;
   localparam logic [7:0] RESET_ROW_CMD    = 8'd43;
   localparam logic [7:0] RESET_WRITE_CMD  = 8'd44;
   localparam logic [7:0] RESET_ROTATE_CMD = 8'd54;

   // Configuration register indexes.
   localparam logic [1:0] CSR_COLUMN_CMD = 2'd0;
   localparam logic [1:0] CSR_ROW_CMD    = 2'd1;
   localparam logic [1:0] CSR_WRITE_CMD  = 2'd2;
   localparam logic [1:0] CSR_ROTATE_CMD = 2'd3;

   // Number of parameter bytes that make one window setting.
   localparam int BYTES_PER_WINDOW = 4;

   // Input word kinds.
   typedef enum logic [1:0] {
      OP_CMD   = 2'd0,
      OP_DATA  = 2'd1,
      OP_COLOR = 2'd2
   } op_type;

   // Display rotation.
   typedef enum logic [1:0] {
      ROT_UP    = 2'd0,
      ROT_LEFT  = 2'd1,
      ROT_RIGHT = 2'd2,
      ROT_DOWN  = 2'd3
   } rotation_type;

   // Command interface mode, one-hot.
   typedef enum logic [4:0] {
      MODE_STREAM = 5'b00001,
      MODE_COLUMN = 5'b00010,
      MODE_ROW    = 5'b00100,
      MODE_WRITE  = 5'b01000,
      MODE_ROTATE = 5'b10000
   } mode_type;

   // Programmed command codes.
   typedef struct packed {
      logic [7:0] column_cmd;
      logic [7:0] row_cmd;
      logic [7:0] write_cmd;
      logic [7:0] rotate_cmd;
   } cmd_codes_type;

   // Pixel request from the command decoder to the result stage.
   typedef struct packed {
      logic         emit;
      logic [8:0]   x;
      logic [15:0]  y;
      logic [15:0]  color;
      rotation_type rotation;
      logic [8:0]   row_end;
   } pix_req_type;

   // Decoder status for checking.
   typedef struct packed {
      logic     in_valid;
      mode_type mode;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/twp_ctrl.sv -----
// ----------------------------------------------------------------------------
// TFT window pixel writer command decoder
// Holds the input word register, decodes commands, gathers window bytes and
// walks the pixel cursor. Flags a pixel request for each word that draws one.
// ----------------------------------------------------------------------------
`default_nettype none

module twp_ctrl #(
   parameter int PANEL_WIDTH  = twp_pkg::DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = twp_pkg::DEFAULT_PANEL_HEIGHT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_op,
   input  wire logic [15:0]              req_value,
   input  wire twp_pkg::cmd_codes_type   codes,
   input  wire logic                     advance,
   output twp_pkg::pix_req_type          pix,
   output twp_pkg::ctrl_status_type      status
);

   localparam logic [15:0] WIDTH_LIM  = 16'(PANEL_WIDTH);
   localparam logic [15:0] HEIGHT_LIM = 16'(PANEL_HEIGHT);
   localparam logic [1:0]  LAST_BYTE  = 2'(twp_pkg::BYTES_PER_WINDOW - 1);

   // Input word register.
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] value_ff, value_in;

   // Command interface state.
   twp_pkg::mode_type     mode_ff, mode_in;
   twp_pkg::rotation_type rotation_ff, rotation_in;
   logic [1:0]            byte_count_ff, byte_count_in;
   logic [7:0]            hold_ff [3];
   logic [7:0]            hold_in [3];
   logic [8:0]            col_anchor_ff, col_anchor_in;
   logic [8:0]            col_cursor_ff, col_cursor_in;
   logic [8:0]            col_end_ff, col_end_in;
   logic [15:0]           row_cursor_ff, row_cursor_in;
   logic [8:0]            row_end_ff, row_end_in;

   logic        fire;
   logic        sideways;
   logic [7:0]  data_byte;
   logic [15:0] col_lim, row_lim;
   logic [15:0] start_word, end_word;
   logic [15:0] start_clamp, end_clamp;

   // The held word is processed once the result stage can take its outcome.
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = req_stall ? 1'b1 : req_valid;
      op_in       = op_ff;
      value_in    = value_ff;
      if (req_valid && !req_stall) begin
         op_in    = req_op;
         value_in = req_value;
      end
   end

   // Window limits follow the logical orientation.
   assign sideways   = (rotation_ff == twp_pkg::ROT_LEFT) ||
                       (rotation_ff == twp_pkg::ROT_RIGHT);
   assign col_lim    = sideways ? HEIGHT_LIM : WIDTH_LIM;
   assign row_lim    = sideways ? WIDTH_LIM : HEIGHT_LIM;
   assign data_byte  = value_ff[7:0];
   assign start_word = {hold_ff[0], hold_ff[1]};
   assign end_word   = {hold_ff[2], data_byte};

   always_comb begin
      if (mode_ff == twp_pkg::MODE_COLUMN) begin
         start_clamp = (start_word >= col_lim) ? col_lim - 16'd1 : start_word;
         end_clamp   = (end_word >= col_lim) ? col_lim - 16'd1 : end_word;
      end else begin
         start_clamp = (start_word >= row_lim) ? row_lim - 16'd1 : start_word;
         end_clamp   = (end_word >= row_lim) ? row_lim - 16'd1 : end_word;
      end
   end

   // Next state and pixel request for the processed word.
   always_comb begin
      mode_in       = mode_ff;
      rotation_in   = rotation_ff;
      byte_count_in = byte_count_ff;
      hold_in       = hold_ff;
      col_anchor_in = col_anchor_ff;
      col_cursor_in = col_cursor_ff;
      col_end_in    = col_end_ff;
      row_cursor_in = row_cursor_ff;
      row_end_in    = row_end_ff;

      pix.emit     = 1'b0;
      pix.x        = col_cursor_ff;
      pix.y        = row_cursor_ff;
      pix.color    = value_ff;
      pix.rotation = rotation_ff;
      pix.row_end  = row_end_ff;

      if (fire) begin
         case (op_ff)
            twp_pkg::OP_CMD: begin
               byte_count_in = 2'd0;
               if (data_byte == codes.column_cmd) begin
                  mode_in = twp_pkg::MODE_COLUMN;
               end else if (data_byte == codes.row_cmd) begin
                  mode_in = twp_pkg::MODE_ROW;
               end else if (data_byte == codes.write_cmd) begin
                  mode_in = twp_pkg::MODE_WRITE;
               end else if (data_byte == codes.rotate_cmd) begin
                  mode_in = twp_pkg::MODE_ROTATE;
               end
            end
            twp_pkg::OP_DATA: begin
               if (mode_ff == twp_pkg::MODE_COLUMN || mode_ff == twp_pkg::MODE_ROW) begin
                  if (byte_count_ff != LAST_BYTE) begin
                     // Collect the leading bytes of start and end.
                     hold_in[byte_count_ff] = data_byte;
                     byte_count_in          = byte_count_ff + 2'd1;
                  end else begin
                     byte_count_in = 2'd0;
                     if (mode_ff == twp_pkg::MODE_COLUMN) begin
                        col_anchor_in = start_clamp[8:0];
                        col_cursor_in = start_clamp[8:0];
                        col_end_in    = end_clamp[8:0];
                     end else begin
                        row_cursor_in = start_clamp;
                        row_end_in    = end_clamp[8:0];
                     end
                  end
               end else if (mode_ff == twp_pkg::MODE_ROTATE) begin
                  // Unknown rotation bytes fall back to the upright view.
                  if (data_byte[7:2] == 6'd0) begin
                     rotation_in = twp_pkg::rotation_type'(data_byte[1:0]);
                  end else begin
                     rotation_in = twp_pkg::ROT_UP;
                  end
               end
            end
            twp_pkg::OP_COLOR: begin
               if (mode_ff == twp_pkg::MODE_WRITE) begin
                  // The first colour is drawn only for a one-pixel window.
                  pix.emit = (col_cursor_ff == col_end_ff) &&
                             (row_cursor_ff == {7'd0, row_end_ff});
                  mode_in  = twp_pkg::MODE_STREAM;
               end else if (mode_ff == twp_pkg::MODE_STREAM) begin
                  pix.emit = 1'b1;
                  if (col_cursor_ff >= col_end_ff) begin
                     col_cursor_in = col_anchor_ff;
                     row_cursor_in = row_cursor_ff + 16'd1;
                  end else begin
                     col_cursor_in = col_cursor_ff + 9'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Input word payload.
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
   end

   // Control and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mode_ff       <= twp_pkg::MODE_STREAM;
         rotation_ff   <= twp_pkg::ROT_UP;
         byte_count_ff <= 2'd0;
         hold_ff       <= '{default: 8'd0};
         col_anchor_ff <= 9'd0;
         col_cursor_ff <= 9'd0;
         col_end_ff    <= 9'd0;
         row_cursor_ff <= 16'd0;
         row_end_ff    <= 9'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         mode_ff       <= mode_in;
         rotation_ff   <= rotation_in;
         byte_count_ff <= byte_count_in;
         hold_ff       <= hold_in;
         col_anchor_ff <= col_anchor_in;
         col_cursor_ff <= col_cursor_in;
         col_end_ff    <= col_end_in;
         row_cursor_ff <= row_cursor_in;
         row_end_ff    <= row_end_in;
      end
   end

   assign status.in_valid = in_valid_ff;
   assign status.mode     = mode_ff;

endmodule

`default_nettype wire

// ----- rtl/core/twp_pixel_out.sv -----
// ----------------------------------------------------------------------------
// TFT window pixel writer result stage
// Maps the logical pixel position to a frame buffer index, flags rows past
// the window and holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module twp_pixel_out #(
   parameter int PANEL_WIDTH  = twp_pkg::DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = twp_pkg::DEFAULT_PANEL_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire twp_pkg::pix_req_type  pix,
   output logic                       rsp_valid,
   output logic [8:0]                 rsp_pix_x,
   output logic [15:0]                rsp_pix_y,
   output logic [15:0]                rsp_color,
   output logic [16:0]                rsp_pixel_index,
   output logic                       rsp_beyond_window
);

   localparam int          MULT_BITS = $clog2(PANEL_WIDTH + 1);
   localparam logic [MULT_BITS-1:0] WIDTH_MULT = MULT_BITS'(PANEL_WIDTH);
   localparam logic [16:0] WIDTH_17  = 17'(PANEL_WIDTH);
   localparam logic [16:0] HEIGHT_17 = 17'(PANEL_HEIGHT);
   localparam logic [15:0] WIDTH_16  = 16'(PANEL_WIDTH);
   localparam logic [15:0] HEIGHT_16 = 16'(PANEL_HEIGHT);

   logic        valid_ff, valid_in;
   logic [8:0]  x_ff;
   logic [15:0] y_ff;
   logic [15:0] color_ff;
   logic [16:0] index_ff, index_in;
   logic        beyond_ff, beyond_in;

   logic [16:0]               x_ext, y_ext;
   logic [16:0]               row_term, col_term;
   logic [17+MULT_BITS-1:0]   product;
   logic                      sideways;
   logic [15:0]               logical_height;

   assign x_ext = {8'd0, pix.x};
   assign y_ext = {1'b0, pix.y};

   // Rotation picks the buffer row and column; the index wraps at 17 bits.
   always_comb begin
      case (pix.rotation)
         twp_pkg::ROT_LEFT: begin
            row_term = x_ext;
            col_term = WIDTH_17 - 17'd1 - y_ext;
         end
         twp_pkg::ROT_RIGHT: begin
            row_term = HEIGHT_17 - 17'd1 - x_ext;
            col_term = y_ext;
         end
         twp_pkg::ROT_DOWN: begin
            row_term = HEIGHT_17 - 17'd1 - y_ext;
            col_term = WIDTH_17 - 17'd1 - x_ext;
         end
         default: begin
            row_term = y_ext;
            col_term = x_ext;
         end
      endcase
   end

   assign product  = {{MULT_BITS{1'b0}}, row_term} * {17'd0, WIDTH_MULT};
   assign index_in = product[16:0] + col_term;

   // A row past the window end or the logical panel is flagged.
   assign sideways       = (pix.rotation == twp_pkg::ROT_LEFT) ||
                           (pix.rotation == twp_pkg::ROT_RIGHT);
   assign logical_height = sideways ? WIDTH_16 : HEIGHT_16;
   assign beyond_in      = (pix.y > {7'd0, pix.row_end}) || (pix.y >= logical_height);

   assign valid_in = advance ? pix.emit : valid_ff;

   // Result payload loads only with a drawn pixel.
   always_ff @(posedge clock) begin
      if (advance && pix.emit) begin
         x_ff      <= pix.x;
         y_ff      <= pix.y;
         color_ff  <= pix.color;
         index_ff  <= index_in;
         beyond_ff <= beyond_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pix_x         = x_ff;
   assign rsp_pix_y         = y_ff;
   assign rsp_color         = color_ff;
   assign rsp_pixel_index   = index_ff;
   assign rsp_beyond_window = beyond_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tft_window_pixel_writer.sv -----
// ----------------------------------------------------------------------------
// TFT window pixel writer
// Command interface of a serial TFT controller in front of a frame buffer.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one word per transfer: a command byte, a window
//   or rotation parameter byte, or an RGB565 colour. A word is taken when
//   req_valid is high and req_stall is low. Drawn pixels leave on the rsp_
//   channel with their logical position, colour, rotated frame buffer index
//   and an out-of-window flag; a word that draws nothing yields no result.
//   The csr_ channel sets the four command codes; csr_ready is always high
//   and writes are meant to happen while the block is idle.
//   A taken word waits in the input register; once processed, its pixel is
//   registered for rsp_. One word per cycle unless rsp_stall holds a pixel,
//   set by the combinational cursor update and constant-width index multiply.
//   While rsp_stall holds a waiting pixel, the input register holds one more
//   word and req_stall rises only once that register is full.
//   Reset (synchronous) empties both registers, returns to pixel streaming
//   with an upright view and a zero window, and loads the default codes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tft_window_pixel_writer_macros.svh"

module tft_window_pixel_writer #(
   parameter int PANEL_WIDTH  = twp_pkg::DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = twp_pkg::DEFAULT_PANEL_HEIGHT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input words.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_value,
   // Drawn pixels.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [8:0]       rsp_pix_x,
   output logic [15:0]      rsp_pix_y,
   output logic [15:0]      rsp_color,
   output logic [16:0]      rsp_pixel_index,
   output logic             rsp_beyond_window,
   // Command code registers.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   twp_pkg::cmd_codes_type    codes_ff, codes_in;
   twp_pkg::pix_req_type      pix;
   twp_pkg::ctrl_status_type  status;
   logic                      advance;

   // Command code registers take a write in any cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      codes_in = codes_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            twp_pkg::CSR_COLUMN_CMD: codes_in.column_cmd = csr_data;
            twp_pkg::CSR_ROW_CMD:    codes_in.row_cmd    = csr_data;
            twp_pkg::CSR_WRITE_CMD:  codes_in.write_cmd  = csr_data;
            twp_pkg::CSR_ROTATE_CMD: codes_in.rotate_cmd = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.column_cmd <= twp_pkg::RESET_COLUMN_CMD;
         codes_ff.row_cmd    <= twp_pkg::RESET_ROW_CMD;
         codes_ff.write_cmd  <= twp_pkg::RESET_WRITE_CMD;
         codes_ff.rotate_cmd <= twp_pkg::RESET_ROTATE_CMD;
      end else begin
         codes_ff <= codes_in;
      end
   end

   // The held word moves on whenever the result register is free or drains.
   assign advance = !rsp_valid || !rsp_stall;

   twp_ctrl #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_value (req_value),
      .codes     (codes_ff),
      .advance   (advance),
      .pix       (pix),
      .status    (status)
   );

   twp_pixel_out #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_pixel_out (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .pix               (pix),
      .rsp_valid         (rsp_valid),
      .rsp_pix_x         (rsp_pix_x),
      .rsp_pix_y         (rsp_pix_y),
      .rsp_color         (rsp_color),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_beyond_window (rsp_beyond_window)
   );

   // Input backpressure only comes from a full input register and a stalled result.
   `TWP_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, status.in_valid && rsp_valid && rsp_stall)

   // A new result can only come from a word held in the input register.
   `TWP_ASSERT_IMPLY(a_result_source, clock, reset, $rose(rsp_valid), $past(status.in_valid))

   // A row inside the window is at most the 9-bit window end.
   `TWP_ASSERT_IMPLY(a_inside_row, clock, reset, rsp_valid && !rsp_beyond_window, rsp_pix_y[15:9] == 7'd0)

endmodule

`default_nettype wire
